[rtl/core/vfs_pkg.sv]
`timescale 1ns / 1ps

package vfs_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned POS_W      = 6;
   localparam int unsigned CRC_W      = 16;
   localparam int unsigned VEL_W      = 32;
   localparam int unsigned CSR_IDX_W  = 2;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [CRC_W-1:0]  crc_type;

   // Frame layout, byte positions
   localparam pos_type POS_SYNC_0  = 6'd0;
   localparam pos_type POS_SYNC_1  = 6'd1;
   localparam pos_type POS_MODE    = 6'd2;
   localparam pos_type POS_TEAM    = 6'd3;
   localparam pos_type POS_X_FIRST = 6'd28;
   localparam pos_type POS_Y_LAST  = 6'd35;
   localparam pos_type POS_SPIN    = 6'd36;
   localparam pos_type POS_CRC_LO  = 6'd37;
   localparam pos_type POS_CRC_HI  = 6'd38;

   localparam byte_type SYNC_BYTE_0 = 8'h53;   // 'S'
   localparam byte_type SYNC_BYTE_1 = 8'h50;   // 'P'
   localparam byte_type ZERO_BYTE   = 8'h00;

   localparam crc_type CRC_INIT = 16'hffff;
   localparam crc_type CRC_POLY = 16'h8408;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_GIMBAL_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TEAM_RED    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPIN_LEVEL  = 2'd2;

   typedef struct packed {
      logic init;
      logic feed;
   } crc_ctrl_type;

   typedef struct packed {
      logic load;
      logic shift;
   } shift_ctrl_type;

endpackage

[rtl/core/vfs_crc_unit.sv]
`timescale 1ns / 1ps

module vfs_crc_unit
   import vfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  crc_ctrl_type ctrl,
   input  byte_type     data_byte,
   output crc_type      crc
);

   crc_type crc_ff;
   crc_type crc_in;

   // Reflected CRC, one byte folded in as eight bit steps
   function automatic crc_type crc_feed_byte(input crc_type c, input byte_type b);
      crc_type acc;
      acc = c ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < BYTE_W; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

   always_comb begin
      priority if (ctrl.init) begin
         crc_in = CRC_INIT;
      end else if (ctrl.feed) begin
         crc_in = crc_feed_byte(crc_ff, data_byte);
      end else begin
         crc_in = crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

[rtl/core/vfs_payload_shifter.sv]
`timescale 1ns / 1ps

module vfs_payload_shifter
   import vfs_pkg::*;
(
   input  logic             clock,
   input  shift_ctrl_type   ctrl,
   input  logic [VEL_W-1:0] x_bits,
   input  logic [VEL_W-1:0] y_bits,
   output byte_type         low_byte
);

   localparam int unsigned SHIFT_W = 2 * VEL_W;

   logic [SHIFT_W-1:0] shift_ff;
   logic [SHIFT_W-1:0] shift_in;

   // x goes out first, low byte first, then y
   always_comb begin
      priority if (ctrl.load) begin
         shift_in = {y_bits, x_bits};
      end else if (ctrl.shift) begin
         shift_in = {{BYTE_W{1'b0}}, shift_ff[SHIFT_W-1:BYTE_W]};
      end else begin
         shift_in = shift_ff;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   assign low_byte = shift_ff[BYTE_W-1:0];

endmodule

[rtl/core/velocity_frame_serializer_unit.sv]
`timescale 1ns / 1ps

// Velocity frame serializer.
// req channel: one transaction carries the x and y velocity bit patterns.
// rsp channel: the block answers with a 39-byte frame, one byte per
// transaction, rsp_frame_end set on the last byte (CRC high byte).
// Frame: 'S' 'P', gimbal mode, team flag, 24 zero bytes, x and y velocity
// little-endian, spin level, then CRC-16 (poly 0x8408 reflected, init 0xffff)
// over the first 37 bytes, low byte first.
// csr port: write enable, register index, data; writes land at once.
// Timing: a taken request starts the frame sequencer at the first byte
// position, from which the first byte is loaded into the output register.
// The single output byte register loads one byte per cycle while rsp_ready
// is held high; the next request is taken in the cycle the last byte is loaded.
// A stalled receiver holds the output register and freezes the frame
// sequencer, the payload shift register and the CRC; req_ready stays low
// until the last byte of the current frame is loaded.
// Reset clears the configuration registers to zero, empties the output and
// readies the request side.

module velocity_frame_serializer_unit
   import vfs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [VEL_W-1:0]     req_x_velocity_bits,
   input  logic [VEL_W-1:0]     req_y_velocity_bits,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BYTE_W-1:0]    rsp_frame_byte,
   output logic                 rsp_frame_end,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   // Configuration registers
   byte_type gimbal_mode_ff;
   byte_type team_red_ff;
   byte_type spin_level_ff;

   // Frame sequencer
   logic     busy_ff;
   logic     busy_in;
   pos_type  pos_ff;
   pos_type  pos_in;

   // Output register
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   byte_type rsp_byte_ff;
   logic     rsp_end_ff;

   logic           advance;
   logic           last_pos;
   logic           accept;
   byte_type       next_byte;
   byte_type       payload_byte;
   crc_type        crc;
   crc_ctrl_type   crc_ctrl;
   shift_ctrl_type shift_ctrl;

   // Advance when a byte is pending and the output register is free
   assign advance   = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign last_pos  = (pos_ff == POS_CRC_HI);
   // Take the next request as the last byte of the frame leaves the sequencer
   assign req_ready = !busy_ff || (advance && last_pos);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gimbal_mode_ff <= '0;
         team_red_ff    <= '0;
         spin_level_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_GIMBAL_MODE: gimbal_mode_ff <= csr_wdata;
            REG_TEAM_RED:    team_red_ff    <= csr_wdata;
            REG_SPIN_LEVEL:  spin_level_ff  <= csr_wdata;
            default: ;       // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      priority if (accept) begin
         busy_in = 1'b1;
         pos_in  = POS_SYNC_0;
      end else if (advance && last_pos) begin
         busy_in = 1'b0;
         pos_in  = POS_SYNC_0;
      end else if (advance) begin
         busy_in = 1'b1;
         pos_in  = pos_ff + 1'b1;
      end else begin
         busy_in = busy_ff;
         pos_in  = pos_ff;
      end
   end

   // Pick the frame byte at the current position
   always_comb begin
      priority if (pos_ff == POS_SYNC_0) begin
         next_byte = SYNC_BYTE_0;
      end else if (pos_ff == POS_SYNC_1) begin
         next_byte = SYNC_BYTE_1;
      end else if (pos_ff == POS_MODE) begin
         next_byte = gimbal_mode_ff;
      end else if (pos_ff == POS_TEAM) begin
         next_byte = team_red_ff;
      end else if (pos_ff < POS_X_FIRST) begin
         next_byte = ZERO_BYTE;
      end else if (pos_ff <= POS_Y_LAST) begin
         next_byte = payload_byte;
      end else if (pos_ff == POS_SPIN) begin
         next_byte = spin_level_ff;
      end else if (pos_ff == POS_CRC_LO) begin
         next_byte = crc[BYTE_W-1:0];
      end else begin
         next_byte = crc[CRC_W-1:BYTE_W];
      end
   end

   // Restart the CRC per frame; fold in every byte up to the spin level
   assign crc_ctrl.init = accept;
   assign crc_ctrl.feed = advance && (pos_ff <= POS_SPIN);

   // Load velocities per frame; move one byte on while they are sent
   assign shift_ctrl.load  = accept;
   assign shift_ctrl.shift = advance && (pos_ff >= POS_X_FIRST) && (pos_ff <= POS_Y_LAST);

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= POS_SYNC_0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload of the output register: hold while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_byte_ff <= next_byte;
         rsp_end_ff  <= last_pos;
      end
   end

   vfs_crc_unit u_crc (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (crc_ctrl),
      .data_byte (next_byte),
      .crc       (crc)
   );

   vfs_payload_shifter u_shifter (
      .clock    (clock),
      .ctrl     (shift_ctrl),
      .x_bits   (req_x_velocity_bits),
      .y_bits   (req_y_velocity_bits),
      .low_byte (payload_byte)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_frame_end  = rsp_end_ff;

endmodule

[rtl/core/vfs_checker.sv]
`timescale 1ns / 1ps

module vfs_checker
   import vfs_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [VEL_W-1:0]     req_x_velocity_bits,
   input logic [VEL_W-1:0]     req_y_velocity_bits,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [BYTE_W-1:0]    rsp_frame_byte,
   input logic                 rsp_frame_end,
   input logic                 csr_wr_en,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [BYTE_W-1:0]    csr_wdata
);

   logic unused_inputs;
   assign unused_inputs = ^{req_x_velocity_bits, req_y_velocity_bits,
                            csr_wr_en, csr_index, csr_wdata};

   // Output empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_frame_byte) && $stable(rsp_frame_end))
      else $error("stalled result changed");

   // One frame at a time: no second request straight after a take
   a_one_frame: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken twice in a row");

   // After the closing byte only a fresh frame header may follow
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_frame_end |=>
         !rsp_valid || (rsp_frame_byte == SYNC_BYTE_0 && !rsp_frame_end))
      else $error("frame does not restart with header");

   // No request taken while a mid-frame byte is stalled
   a_busy_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !rsp_frame_end |-> !req_ready)
      else $error("request side open mid-frame");

endmodule

bind velocity_frame_serializer_unit vfs_checker u_vfs_checker (.*);

[verif/velocity_frame_serializer_unit_tb.sv]
`timescale 1ns / 1ps

module velocity_frame_serializer_unit_tb;
   import vfs_pkg::*;

   localparam int FRAME_BYTES   = int'(POS_CRC_HI) + 1;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 50;
   localparam int IDLE_PERCENT  = 29;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 51;
   localparam int HOLD_OFF      = 300;

   // Index with no register behind it: the write must leave every register alone
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef enum logic {STEP_ITEM, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type        kind;
      logic [CSR_IDX_W-1:0] index;
      byte_type             data;
      logic [VEL_W-1:0]     x;
      logic [VEL_W-1:0]     y;
   } step_type;

   typedef struct {
      byte_type value;
      logic     last;
   } frame_entry_type;

   // Directed part: velocity extremes and float specials, every register at
   // both ends, and writes to the index with no register behind it. Every
   // frame byte, CRC included, is checked against the frame predictor.
   localparam int DIRECTED_LEN = 25;
   localparam step_type DIRECTED [DIRECTED_LEN] = '{
      '{STEP_ITEM, REG_GIMBAL_MODE, 8'h00, 32'h0000_0000, 32'h0000_0000}, // straight after reset
      '{STEP_ITEM, REG_GIMBAL_MODE, 8'h00, 32'hffff_ffff, 32'hffff_ffff},
      '{STEP_ITEM, REG_GIMBAL_MODE, 8'h00, 32'h7fc0_0000, 32'h7f80_0000}, // NaN, +inf
      '{STEP_ITEM, REG_GIMBAL_MODE, 8'h00, 32'hff80_0000, 32'h8000_0000}, // -inf, -0
      '{STEP_ITEM, REG_GIMBAL_MODE, 8'h00, 32'h0000_0001, 32'h7f7f_ffff}, // denormal, max
      '{STEP_ITEM, REG_GIMBAL_MODE, 8'h00, 32'h1234_5678, 32'h89ab_cdef}, // byte order
      '{STEP_CSR,  REG_GIMBAL_MODE, 8'h01, 32'h0000_0000, 32'h0000_0000}, // aim
      '{STEP_CSR,  REG_TEAM_RED,    8'h01, 32'h0000_0000, 32'h0000_0000},
      '{STEP_ITEM, REG_GIMBAL_MODE, 8'h00, 32'h3f80_0000, 32'hbf80_0000},
      '{STEP_CSR,  REG_GIMBAL_MODE, 8'h02, 32'h0000_0000, 32'h0000_0000}, // aim and fire
      '{STEP_CSR,  REG_SPIN_LEVEL,  8'h01, 32'h0000_0000, 32'h0000_0000},
      '{STEP_ITEM, REG_GIMBAL_MODE, 8'h00, 32'h0000_0000, 32'hffff_ffff},
      '{STEP_CSR,  REG_GIMBAL_MODE, 8'hff, 32'h0000_0000, 32'h0000_0000},
      '{STEP_CSR,  REG_TEAM_RED,    8'hff, 32'h0000_0000, 32'h0000_0000},
      '{STEP_CSR,  REG_SPIN_LEVEL,  8'hff, 32'h0000_0000, 32'h0000_0000},
      '{STEP_ITEM, REG_GIMBAL_MODE, 8'h00, 32'ha5a5_a5a5, 32'h5a5a_5a5a},
      '{STEP_CSR,  REG_UNUSED,      8'h00, 32'h0000_0000, 32'h0000_0000}, // ignored
      '{STEP_ITEM, REG_GIMBAL_MODE, 8'h00, 32'hffff_ffff, 32'h0000_0000},
      '{STEP_CSR,  REG_UNUSED,      8'hff, 32'h0000_0000, 32'h0000_0000}, // ignored
      '{STEP_ITEM, REG_GIMBAL_MODE, 8'h00, 32'h0000_0000, 32'h0000_0000},
      '{STEP_CSR,  REG_GIMBAL_MODE, 8'h00, 32'h0000_0000, 32'h0000_0000},
      '{STEP_CSR,  REG_TEAM_RED,    8'h00, 32'h0000_0000, 32'h0000_0000},
      '{STEP_CSR,  REG_SPIN_LEVEL,  8'h00, 32'h0000_0000, 32'h0000_0000},
      '{STEP_ITEM, REG_GIMBAL_MODE, 8'h00, 32'h7fff_ffff, 32'hff7f_ffff},
      '{STEP_ITEM, REG_GIMBAL_MODE, 8'h00, 32'hc2c8_0000, 32'h42c8_0000}
   };

   // Float patterns worth hitting now and then in the random part
   localparam logic [VEL_W-1:0] SPECIALS [8] = '{
      32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
      32'h7fc0_0000, 32'hffff_ffff, 32'h0000_0001, 32'h7f7f_ffff
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid;
   logic                 req_ready;
   logic [VEL_W-1:0]     req_x_velocity_bits;
   logic [VEL_W-1:0]     req_y_velocity_bits;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [BYTE_W-1:0]    rsp_frame_byte;
   logic                 rsp_frame_end;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wdata;

   // Register copies that feed the frame predictor
   byte_type cfg_gimbal_mode = '0;
   byte_type cfg_team_red    = '0;
   byte_type cfg_spin_level  = '0;

   frame_entry_type expected_frame_bytes [$];
   int              mismatch_count  = 0;
   int              cycle_count     = 0;
   bit              steady_stretch  = 1'b0; // both sides stay busy while set
   int              rsp_hold_cycles = 0;    // receiver hold-off request

   velocity_frame_serializer_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_x_velocity_bits (req_x_velocity_bits),
      .req_y_velocity_bits (req_y_velocity_bits),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_frame_byte      (rsp_frame_byte),
      .rsp_frame_end       (rsp_frame_end),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #5 clock = ~clock;

   // Give up well beyond the slowest legal run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Reflected CRC-16, one byte in, LSB first
   function automatic crc_type crc_absorb(crc_type crc, byte_type b);
      crc_type c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   // Build the whole frame for one accepted transaction and queue its bytes
   function automatic void predict_frame(logic [VEL_W-1:0] x, logic [VEL_W-1:0] y);
      crc_type         crc;
      byte_type        b;
      frame_entry_type entry;
      crc = CRC_INIT;
      for (int pos = 0; pos < FRAME_BYTES; pos++) begin
         if (pos == int'(POS_SYNC_0)) begin
            b = SYNC_BYTE_0;
         end else if (pos == int'(POS_SYNC_1)) begin
            b = SYNC_BYTE_1;
         end else if (pos == int'(POS_MODE)) begin
            b = cfg_gimbal_mode;
         end else if (pos == int'(POS_TEAM)) begin
            b = cfg_team_red;
         end else if (pos < int'(POS_X_FIRST)) begin
            b = ZERO_BYTE;
         end else if (pos < int'(POS_X_FIRST) + 4) begin
            b = byte_type'(x >> (8 * (pos - int'(POS_X_FIRST))));
         end else if (pos <= int'(POS_Y_LAST)) begin
            b = byte_type'(y >> (8 * (pos - int'(POS_X_FIRST) - 4)));
         end else if (pos == int'(POS_SPIN)) begin
            b = cfg_spin_level;
         end else if (pos == int'(POS_CRC_LO)) begin
            b = crc[7:0];
         end else begin
            b = crc[15:8];
         end
         // the CRC covers everything up to and including the spin level
         if (pos < int'(POS_CRC_LO))
            crc = crc_absorb(crc, b);
         entry.value = b;
         entry.last  = (pos == int'(POS_CRC_HI));
         expected_frame_bytes.push_back(entry);
      end
   endfunction

   function automatic logic [VEL_W-1:0] pick_velocity();
      if ($urandom_range(9) == 0)
         return SPECIALS[$urandom_range(7)];
      return $urandom;
   endfunction

   // Offer one velocity transaction, idling first at random; hold valid and
   // payload until taken, then queue the frame it must produce
   task automatic send_velocity(input logic [VEL_W-1:0] x, input logic [VEL_W-1:0] y);
      csr_wr_en <= 1'b0;
      while (!steady_stretch && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_x_velocity_bits <= x;
      req_y_velocity_bits <= y;
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_frame(x, y);
   endtask

   // Drop valid and wait for every outstanding frame byte to come back
   task automatic settle_frames();
      req_valid <= 1'b0;
      while (expected_frame_bytes.size() != 0)
         @(posedge clock);
   endtask

   // One register write; the block is idle whenever this is called
   task automatic write_register(input logic [CSR_IDX_W-1:0] index, input byte_type data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         REG_GIMBAL_MODE: cfg_gimbal_mode = data;
         REG_TEAM_RED:    cfg_team_red    = data;
         REG_SPIN_LEVEL:  cfg_spin_level  = data;
         default: ;  // no register here, drop the write
      endcase
   endtask

   // Receiver: random back-pressure, plus a long hold-off on request so the
   // block fills up and stalls its input side
   initial begin
      rsp_ready <= 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         if (rsp_hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         rsp_ready <= steady_stretch || ($urandom_range(99) >= IDLE_PERCENT);
         @(posedge clock);
      end
   end

   // Check every frame byte transaction against the oldest expectation
   always @(posedge clock) begin : frame_check
      frame_entry_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_frame_bytes.size() == 0) begin
            $error("unexpected frame byte %02h (frame_end %0b)", rsp_frame_byte, rsp_frame_end);
            mismatch_count++;
         end else begin
            want = expected_frame_bytes.pop_front();
            if (rsp_frame_byte !== want.value) begin
               $error("frame_byte: expected %02h, got %02h", want.value, rsp_frame_byte);
               mismatch_count++;
            end
            if (rsp_frame_end !== want.last) begin
               $error("frame_end: expected %0b, got %0b", want.last, rsp_frame_end);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      req_valid           <= 1'b0;
      req_x_velocity_bits <= '0;
      req_y_velocity_bits <= '0;
      csr_wr_en           <= 1'b0;
      csr_index           <= REG_GIMBAL_MODE;
      csr_wdata           <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed steps; register writes only once the block is idle
      for (int i = 0; i < DIRECTED_LEN; i++) begin
         if (DIRECTED[i].kind == STEP_CSR) begin
            settle_frames();
            write_register(DIRECTED[i].index, DIRECTED[i].data);
         end else begin
            send_velocity(DIRECTED[i].x, DIRECTED[i].y);
         end
      end

      // Random phases: fresh register settings, then a run of transactions
      for (int phase = 0; phase < PHASES; phase++) begin
         settle_frames();
         if ($urandom_range(2) == 0)
            write_register(REG_UNUSED, byte_type'($urandom));
         if (phase == 0) begin
            write_register(REG_GIMBAL_MODE, 8'h00);
            write_register(REG_TEAM_RED, 8'h00);
            write_register(REG_SPIN_LEVEL, 8'h00);
         end else if (phase == 1) begin
            write_register(REG_GIMBAL_MODE, 8'hff);
            write_register(REG_TEAM_RED, 8'hff);
            write_register(REG_SPIN_LEVEL, 8'hff);
         end else begin
            write_register(REG_GIMBAL_MODE, byte_type'($urandom_range(255)));
            write_register(REG_TEAM_RED, byte_type'($urandom_range(255)));
            write_register(REG_SPIN_LEVEL, byte_type'($urandom_range(255)));
         end

         // one phase runs flat out on both sides
         steady_stretch = (phase == 2);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold the receiver off while the sender keeps offering
            if (phase == 3 && n == 5)
               rsp_hold_cycles = HOLD_OFF;
            // pause the sender until the last frame has fully drained
            if (phase == 4 && n == 20)
               settle_frames();
            send_velocity(pick_velocity(), pick_velocity());
         end
         steady_stretch = 1'b0;
      end

      settle_frames();
      // advance a little further so any stray byte shows up
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
